// File: rtl/uacrh_pkg.sv
// Shared types and constants for the USB audio control request handler.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package uacrh_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    // Response status codes
    localparam logic [1:0] ST_ACK   = 2'd0;
    localparam logic [1:0] ST_STALL = 2'd1;
    localparam logic [1:0] ST_FWD   = 2'd2;

    // Request type field (bits 6:5)
    localparam logic [1:0] KIND_STANDARD = 2'd0;
    localparam logic [1:0] KIND_CLASS    = 2'd1;

    // Standard request codes
    localparam logic [7:0] RQ_GET_STATUS        = 8'h00;
    localparam logic [7:0] RQ_CLEAR_FEATURE     = 8'h01;
    localparam logic [7:0] RQ_SET_FEATURE       = 8'h03;
    localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'h06;
    localparam logic [7:0] RQ_GET_CONFIGURATION = 8'h08;
    localparam logic [7:0] RQ_SET_CONFIGURATION = 8'h09;
    localparam logic [7:0] RQ_GET_INTERFACE     = 8'h0A;
    localparam logic [7:0] RQ_SET_INTERFACE     = 8'h0B;

    // Audio class request codes
    localparam logic [7:0] AC_SET_CUR = 8'h01;
    localparam logic [7:0] AC_GET_CUR = 8'h81;
    localparam logic [7:0] AC_GET_MIN = 8'h82;
    localparam logic [7:0] AC_GET_MAX = 8'h83;
    localparam logic [7:0] AC_GET_RES = 8'h84;

    // Feature unit control selectors
    localparam logic [7:0] SEL_MUTE   = 8'h01;
    localparam logic [7:0] SEL_VOLUME = 8'h02;

    // Descriptor types
    localparam logic [7:0] DESC_DEVICE = 8'h01;
    localparam logic [7:0] DESC_CONFIG = 8'h02;
    localparam logic [7:0] DESC_STRING = 8'h03;

    // Interface numbers that carry an alternate setting
    localparam logic [7:0] IFACE_FIRST  = 8'h01;
    localparam logic [7:0] IFACE_SECOND = 8'h02;

    // Volume limits, signed 1/256 dB
    localparam logic [15:0] VOL_MIN = 16'hA000;  // -96 dB
    localparam logic [15:0] VOL_MAX = 16'h0000;  // 0 dB
    localparam logic [15:0] VOL_RES = 16'h0100;  // 1 dB

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_UNIT_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_UNIT_ID  = 1'd1;
    localparam logic [7:0] PLAY_UNIT_ID_RST = 8'd2;
    localparam logic [7:0] CAP_UNIT_ID_RST  = 8'd5;

    typedef struct packed {
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] value_word;
        logic [15:0] index_word;
        logic [1:0]  payload_len;
        logic [7:0]  payload_low;
        logic [7:0]  payload_high;
    } uacrh_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] reply_count;
        logic [7:0] reply_low;
        logic [7:0] reply_high;
    } uacrh_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // load the request register
        logic commit;   // update state, load the response register
    } uacrh_cmd_t;

endpackage

`default_nettype wire

// File: rtl/uacrh_channels.sv
// Handshake channel interfaces: request, response and configuration write.
// Depends on uacrh_pkg for the register index width.
`default_nettype none

interface uacrh_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [1:0]  payload_len;
    logic [7:0]  payload_low;
    logic [7:0]  payload_high;

    modport source (
        output valid, request_type, request_code, value_word, index_word,
               payload_len, payload_low, payload_high,
        input  ready
    );
    modport sink (
        input  valid, request_type, request_code, value_word, index_word,
               payload_len, payload_low, payload_high,
        output ready
    );
endinterface

interface uacrh_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] reply_count;
    logic [7:0] reply_low;
    logic [7:0] reply_high;

    modport source (
        output valid, status, reply_count, reply_low, reply_high,
        input  ready
    );
    modport sink (
        input  valid, status, reply_count, reply_low, reply_high,
        output ready
    );
endinterface

interface uacrh_cfg_if
    import uacrh_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/uacrh_ctrl.sv
// Sequencing controller: request capture, commit and response valid.
// Depends on uacrh_pkg for the command struct.
`default_nettype none

module uacrh_ctrl
    import uacrh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output uacrh_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && (state_reg == S_IDLE);
    // Commit only when the response slot is free or draining this cycle
    assign cmd.commit  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/uacrh_dp.sv
// Datapath: request register, decode, device and feature unit state,
// configuration registers and the response register.
// Depends on uacrh_pkg for codes, constants and structs.
`default_nettype none

module uacrh_dp
    import uacrh_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire uacrh_cmd_t           cmd,
    input  wire uacrh_req_t           req_in,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    output uacrh_rsp_t                rsp_out
);

    uacrh_req_t  req_reg;
    uacrh_rsp_t  rsp_reg, rsp_next;

    logic [7:0]  play_unit_id_reg;
    logic [7:0]  cap_unit_id_reg;
    logic [7:0]  active_cfg_reg;
    logic [7:0]  alt_setting_reg [2];
    logic        mute_reg [2];
    logic [15:0] volume_reg [2];

    // Write strobes from decode
    logic        set_cfg;
    logic        set_alt;
    logic        set_mute;
    logic        set_volume;
    logic        iface_ok;
    logic        iface_sel;
    logic        unit_sel;
    logic        unit_ok;
    logic [15:0] vol_value;

    always_comb
    begin
        logic [1:0] kind;
        logic       to_host;
        logic [7:0] code;
        logic [7:0] sel;
        logic [7:0] ifn;
        logic [7:0] unit;

        kind    = req_reg.request_type[6:5];
        to_host = req_reg.request_type[7];
        code    = req_reg.request_code;
        sel     = req_reg.value_word[15:8];
        ifn     = req_reg.index_word[7:0];
        unit    = req_reg.index_word[15:8];

        iface_ok  = (ifn == IFACE_FIRST) || (ifn == IFACE_SECOND);
        iface_sel = (ifn == IFACE_SECOND);
        unit_ok   = (unit == play_unit_id_reg) || (unit == cap_unit_id_reg);
        // Playback wins when both ids match
        unit_sel  = (unit != play_unit_id_reg);

        set_cfg    = 1'b0;
        set_alt    = 1'b0;
        set_mute   = 1'b0;
        set_volume = 1'b0;
        vol_value  = '0;
        rsp_next   = '{status: ST_STALL, reply_count: 2'd0,
                       reply_low: 8'd0, reply_high: 8'd0};

        if (kind == KIND_STANDARD)
        begin
            unique case (code) inside
                RQ_GET_DESCRIPTOR:
                begin
                    if ((sel == DESC_DEVICE) || (sel == DESC_CONFIG) || (sel == DESC_STRING))
                    begin
                        rsp_next.status = ST_FWD;
                    end
                end
                RQ_SET_CONFIGURATION:
                begin
                    set_cfg         = 1'b1;
                    rsp_next.status = ST_ACK;
                end
                RQ_GET_CONFIGURATION:
                begin
                    rsp_next.status      = ST_ACK;
                    rsp_next.reply_count = 2'd1;
                    rsp_next.reply_low   = active_cfg_reg;
                end
                RQ_SET_INTERFACE:
                begin
                    set_alt         = iface_ok;
                    rsp_next.status = ST_ACK;
                end
                RQ_GET_INTERFACE:
                begin
                    rsp_next.status      = ST_ACK;
                    rsp_next.reply_count = 2'd1;
                    rsp_next.reply_low   = iface_ok ? alt_setting_reg[iface_sel] : 8'd0;
                end
                RQ_GET_STATUS:
                begin
                    rsp_next.status      = ST_ACK;
                    rsp_next.reply_count = 2'd2;
                end
                RQ_CLEAR_FEATURE, RQ_SET_FEATURE:
                begin
                    rsp_next.status = ST_ACK;
                end
                default:
                begin
                    rsp_next.status = ST_STALL;
                end
            endcase
        end
        else if ((kind == KIND_CLASS) && unit_ok)
        begin
            if (to_host)
            begin
                if (sel == SEL_MUTE)
                begin
                    if (code == AC_GET_CUR)
                    begin
                        rsp_next.status      = ST_ACK;
                        rsp_next.reply_count = 2'd1;
                        rsp_next.reply_low   = {7'd0, mute_reg[unit_sel]};
                    end
                end
                else if (sel == SEL_VOLUME)
                begin
                    rsp_next.status      = ST_ACK;
                    rsp_next.reply_count = 2'd2;
                    unique case (code)
                        AC_GET_CUR: vol_value = volume_reg[unit_sel];
                        AC_GET_MIN: vol_value = VOL_MIN;
                        AC_GET_MAX: vol_value = VOL_MAX;
                        AC_GET_RES: vol_value = VOL_RES;
                        default:
                        begin
                            rsp_next.status      = ST_STALL;
                            rsp_next.reply_count = 2'd0;
                        end
                    endcase
                    rsp_next.reply_low  = vol_value[7:0];
                    rsp_next.reply_high = vol_value[15:8];
                end
            end
            else if (code == AC_SET_CUR)
            begin
                // Short payloads stall; a length of three counts as two
                if ((sel == SEL_MUTE) && (req_reg.payload_len != 2'd0))
                begin
                    set_mute        = 1'b1;
                    rsp_next.status = ST_ACK;
                end
                else if ((sel == SEL_VOLUME) && req_reg.payload_len[1])
                begin
                    set_volume      = 1'b1;
                    rsp_next.status = ST_ACK;
                end
            end
        end
    end

    // Request and response payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_in;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Configuration and device state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_unit_id_reg   <= PLAY_UNIT_ID_RST;
            cap_unit_id_reg    <= CAP_UNIT_ID_RST;
            active_cfg_reg     <= 8'd0;
            alt_setting_reg[0] <= 8'd0;
            alt_setting_reg[1] <= 8'd0;
            mute_reg[0]        <= 1'b0;
            mute_reg[1]        <= 1'b0;
            volume_reg[0]      <= 16'd0;
            volume_reg[1]      <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PLAY_UNIT_ID: play_unit_id_reg <= cfg_data;
                    CFG_CAP_UNIT_ID:  cap_unit_id_reg  <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.commit)
            begin
                if (set_cfg)
                begin
                    active_cfg_reg <= req_reg.value_word[7:0];
                end
                if (set_alt)
                begin
                    alt_setting_reg[iface_sel] <= req_reg.value_word[7:0];
                end
                if (set_mute)
                begin
                    mute_reg[unit_sel] <= (req_reg.payload_low != 8'd0);
                end
                if (set_volume)
                begin
                    volume_reg[unit_sel] <= {req_reg.payload_high, req_reg.payload_low};
                end
            end
        end
    end

    assign rsp_out = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/usb_audio_control_request_handler.sv
// USB audio control request handler: one decoded setup request in, one
// ACK / STALL / forwarded response with up to two reply bytes out. Inside the
// block each request is first captured into the request register, then
// decoded, updating the device or feature unit state and loading the response
// register. The next request is accepted while a response still waits on rsp;
// the decode step waits only if that response register is still full. A new
// request is taken only after the previous one has been decoded.
// Standard requests cover configuration, alternate setting for interfaces 1
// and 2, status and feature; GET_DESCRIPTOR for device, configuration or string
// returns the forwarded status with no bytes so an external ROM can answer.
// Class requests address the playback or capture feature unit by the unit id
// in the high byte of index_word (playback wins on equal ids): mute GET_CUR /
// SET_CUR and volume GET_CUR/MIN/MAX/RES / SET_CUR, volume in signed 1/256 dB.
// Reply bytes beyond reply_count are zero. Configuration writes on cfg are
// always accepted (cfg.ready tied high); write them only while the block is idle.
// Depends on uacrh_pkg, uacrh_channels, uacrh_ctrl and uacrh_dp.
`default_nettype none

module usb_audio_control_request_handler
    import uacrh_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    uacrh_req_if.sink   req,
    uacrh_rsp_if.source rsp,
    uacrh_cfg_if.sink   cfg
);

    uacrh_cmd_t cmd;
    uacrh_req_t req_bus;
    uacrh_rsp_t rsp_bus;

    // Gather the request fields
    assign req_bus.request_type = req.request_type;
    assign req_bus.request_code = req.request_code;
    assign req_bus.value_word   = req.value_word;
    assign req_bus.index_word   = req.index_word;
    assign req_bus.payload_len  = req.payload_len;
    assign req_bus.payload_low  = req.payload_low;
    assign req_bus.payload_high = req.payload_high;

    // Register writes never stall
    assign cfg.ready = 1'b1;

    uacrh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    uacrh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_in    (req_bus),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .rsp_out   (rsp_bus)
    );

    // Drive the response channel from the response register
    assign rsp.status      = rsp_bus.status;
    assign rsp.reply_count = rsp_bus.reply_count;
    assign rsp.reply_low   = rsp_bus.reply_low;
    assign rsp.reply_high  = rsp_bus.reply_high;

    // A captured request blocks further requests until it is committed
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while previous request still in decode");

    // Capture and commit never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");

    // A commit always presents a response in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("committed response not presented");

    // Stall and forward responses carry no reply bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_ACK)) |->
            ((rsp.reply_count == 2'd0) && (rsp.reply_low == 8'd0) &&
             (rsp.reply_high == 8'd0)))
        else $error("non-acknowledge response with reply data");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for usb_audio_control_request_handler.
// Predicts every response from its own model of the device and feature unit state.
// Depends on uacrh_pkg, uacrh_channels and usb_audio_control_request_handler from rtl/.
`default_nettype none

module testbench;
    import uacrh_pkg::*;

    // Request type byte: direction bit, kind in bits 6:5, recipient in bits 4:0
    localparam logic [1:0] KIND_VENDOR   = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam logic [7:0] TYPE_STD_OUT   = {1'b0, KIND_STANDARD, 5'd0};
    localparam logic [7:0] TYPE_STD_IN    = {1'b1, KIND_STANDARD, 5'd0};
    localparam logic [7:0] TYPE_CLASS_OUT = {1'b0, KIND_CLASS, 5'd1};
    localparam logic [7:0] TYPE_CLASS_IN  = {1'b1, KIND_CLASS, 5'd1};
    localparam logic [7:0] TYPE_VENDOR    = {1'b0, KIND_VENDOR, 5'd0};
    localparam logic [7:0] TYPE_RESERVED  = {1'b1, KIND_RESERVED, 5'd31};

    // Codes the block does not know
    localparam logic [7:0] RQ_UNKNOWN  = 8'hFF;
    localparam logic [7:0] SEL_UNKNOWN = 8'h00;
    localparam logic [7:0] DESC_OTHER  = 8'hFF;
    localparam logic [7:0] UNIT_NONE   = 8'hFF;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 4;
    localparam int SETTLE_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 360;

    logic clk = 1'b0;
    logic rst_n;

    uacrh_req_if req_ch ();
    uacrh_rsp_if rsp_ch ();
    uacrh_cfg_if cfg_ch ();

    usb_audio_control_request_handler u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // Expected device state, mirrored from accepted requests and register writes
    logic [7:0]  exp_play_id;
    logic [7:0]  exp_cap_id;
    logic [7:0]  exp_config_value;
    logic [7:0]  exp_alt[2];
    logic        exp_mute[2];
    logic [15:0] exp_volume[2];

    uacrh_rsp_t expected_replies[$];

    int error_count    = 0;
    int requests_sent  = 0;  // advanced by the sender at each accepted request
    int results_seen   = 0;  // advanced by the monitor at each accepted response
    int stall_cycles   = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;

    // ------------------------------------------------------------------
    // Device model
    // ------------------------------------------------------------------

    function automatic void reset_expected_state();
        exp_play_id      = PLAY_UNIT_ID_RST;
        exp_cap_id       = CAP_UNIT_ID_RST;
        exp_config_value = 8'd0;
        for (int i = 0; i < 2; i++)
        begin
            exp_alt[i]    = 8'd0;
            exp_mute[i]   = 1'b0;
            exp_volume[i] = 16'd0;
        end
    endfunction

    // Work out the response to one request and apply its side effects to
    // the mirrored state. Anything not matched below stalls.
    function automatic uacrh_rsp_t predict_response(input uacrh_req_t r);
        uacrh_rsp_t  a;
        logic [7:0]  ifn;
        logic [7:0]  unit;
        logic [7:0]  sel;
        logic [15:0] v;
        logic        known;
        int          u;

        a        = '0;
        a.status = ST_STALL;
        ifn      = r.index_word[7:0];
        unit     = r.index_word[15:8];
        sel      = r.value_word[15:8];
        v        = 16'd0;
        known    = 1'b1;

        if (r.request_type[6:5] == KIND_STANDARD)
        begin
            // Direction is not checked on standard requests
            case (r.request_code)
                RQ_GET_DESCRIPTOR:
                    if (sel == DESC_DEVICE || sel == DESC_CONFIG || sel == DESC_STRING)
                        a.status = ST_FWD;
                RQ_SET_CONFIGURATION:
                begin
                    exp_config_value = r.value_word[7:0];
                    a.status         = ST_ACK;
                end
                RQ_GET_CONFIGURATION:
                begin
                    a.status      = ST_ACK;
                    a.reply_count = 2'd1;
                    a.reply_low   = exp_config_value;
                end
                RQ_SET_INTERFACE:
                begin
                    // Other interfaces are acknowledged and left alone
                    if (ifn == IFACE_FIRST)
                        exp_alt[0] = r.value_word[7:0];
                    else if (ifn == IFACE_SECOND)
                        exp_alt[1] = r.value_word[7:0];
                    a.status = ST_ACK;
                end
                RQ_GET_INTERFACE:
                begin
                    a.status      = ST_ACK;
                    a.reply_count = 2'd1;
                    if (ifn == IFACE_FIRST)
                        a.reply_low = exp_alt[0];
                    else if (ifn == IFACE_SECOND)
                        a.reply_low = exp_alt[1];
                end
                RQ_GET_STATUS:
                begin
                    a.status      = ST_ACK;
                    a.reply_count = 2'd2;
                end
                RQ_CLEAR_FEATURE, RQ_SET_FEATURE:
                    a.status = ST_ACK;
                default: ;
            endcase
        end
        else if (r.request_type[6:5] == KIND_CLASS)
        begin
            // Playback wins when both ids match
            if (unit == exp_play_id)
                u = 0;
            else if (unit == exp_cap_id)
                u = 1;
            else
                u = -1;

            if (u >= 0 && r.request_type[7])
            begin
                if (sel == SEL_MUTE && r.request_code == AC_GET_CUR)
                begin
                    a.status      = ST_ACK;
                    a.reply_count = 2'd1;
                    a.reply_low   = {7'd0, exp_mute[u]};
                end
                else if (sel == SEL_VOLUME)
                begin
                    case (r.request_code)
                        AC_GET_CUR: v = exp_volume[u];
                        AC_GET_MIN: v = VOL_MIN;
                        AC_GET_MAX: v = VOL_MAX;
                        AC_GET_RES: v = VOL_RES;
                        default:    known = 1'b0;
                    endcase
                    if (known)
                    begin
                        a.status                   = ST_ACK;
                        a.reply_count              = 2'd2;
                        {a.reply_high, a.reply_low} = v;
                    end
                end
            end
            else if (u >= 0 && r.request_code == AC_SET_CUR)
            begin
                // A payload length of three counts as two
                if (sel == SEL_MUTE && r.payload_len >= 2'd1)
                begin
                    exp_mute[u] = (r.payload_low != 8'd0);
                    a.status    = ST_ACK;
                end
                else if (sel == SEL_VOLUME && r.payload_len >= 2'd2)
                begin
                    exp_volume[u] = {r.payload_high, r.payload_low};
                    a.status      = ST_ACK;
                end
            end
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: mirror register writes, predict on each accepted request,
    // check each accepted response, and watch for a hung handshake.
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        uacrh_req_t seen_req;
        uacrh_rsp_t want;
        logic       moved;

        if (rst_n)
        begin
            moved = 1'b0;

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                moved = 1'b1;
                if (cfg_ch.index == CFG_PLAY_UNIT_ID)
                    exp_play_id = cfg_ch.data;
                else if (cfg_ch.index == CFG_CAP_UNIT_ID)
                    exp_cap_id = cfg_ch.data;
            end

            if (req_ch.valid && req_ch.ready)
            begin
                moved    = 1'b1;
                seen_req = '{request_type: req_ch.request_type,
                             request_code: req_ch.request_code,
                             value_word:   req_ch.value_word,
                             index_word:   req_ch.index_word,
                             payload_len:  req_ch.payload_len,
                             payload_low:  req_ch.payload_low,
                             payload_high: req_ch.payload_high};
                expected_replies = {expected_replies, predict_response(seen_req)};
            end

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                results_seen++;
                if (expected_replies.size() == 0)
                begin
                    $error("response with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("status", 8'(want.status), 8'(rsp_ch.status));
                    check_field("reply_count", 8'(want.reply_count), 8'(rsp_ch.reply_count));
                    check_field("reply_low", want.reply_low, rsp_ch.reply_low);
                    check_field("reply_high", want.reply_high, rsp_ch.reply_high);
                end
            end

            // Drop out if nothing moves on any channel for too long
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Response sink: stall at the rate of the current phase
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic uacrh_req_t make_request(
        input logic [7:0] rtype, input logic [7:0] code, input logic [15:0] value,
        input logic [15:0] index, input logic [1:0] len, input logic [7:0] lo,
        input logic [7:0] hi);
        return '{request_type: rtype, request_code: code, value_word: value,
                 index_word: index, payload_len: len, payload_low: lo,
                 payload_high: hi};
    endfunction

    // Present one request, idling first at the sender's rate, and hold it
    // until accepted. Valid stays high afterwards so back-to-back requests
    // need no second assignment in the same step.
    task automatic send_request(input uacrh_req_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.request_type <= r.request_type;
        req_ch.request_code <= r.request_code;
        req_ch.value_word   <= r.value_word;
        req_ch.index_word   <= r.index_word;
        req_ch.payload_len  <= r.payload_len;
        req_ch.payload_low  <= r.payload_low;
        req_ch.payload_high <= r.payload_high;
        do
            @(posedge clk);
        while (!req_ch.ready);
        requests_sent++;
    endtask

    // Drop valid and hold off until every outstanding response is back,
    // then let the pipeline settle.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        while (results_seen != requests_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both unit id registers; call only with the block idle
    task automatic write_unit_ids(input logic [7:0] play_id, input logic [7:0] cap_id);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_PLAY_UNIT_ID;
        cfg_ch.data  <= play_id;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.index <= CFG_CAP_UNIT_ID;
        cfg_ch.data  <= cap_id;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed standard and class requests with random content;
    // the rest is left fully random as noise.
    function automatic uacrh_req_t random_request();
        uacrh_req_t r;
        int         pick;

        r = '{request_type: 8'($urandom), request_code: 8'($urandom),
              value_word: 16'($urandom), index_word: 16'($urandom),
              payload_len: 2'($urandom), payload_low: 8'($urandom),
              payload_high: 8'($urandom)};
        pick = $urandom_range(99);

        if (pick < 35)
        begin
            r.request_type[6:5] = KIND_STANDARD;
            case ($urandom_range(9))
                0: r.request_code = RQ_GET_STATUS;
                1: r.request_code = RQ_CLEAR_FEATURE;
                2: r.request_code = RQ_SET_FEATURE;
                3: r.request_code = RQ_GET_DESCRIPTOR;
                4: r.request_code = RQ_GET_CONFIGURATION;
                5: r.request_code = RQ_SET_CONFIGURATION;
                6: r.request_code = RQ_GET_INTERFACE;
                7: r.request_code = RQ_SET_INTERFACE;
                default: ;
            endcase
            case ($urandom_range(3))
                0: r.value_word[15:8] = DESC_DEVICE;
                1: r.value_word[15:8] = DESC_CONFIG;
                2: r.value_word[15:8] = DESC_STRING;
                default: ;
            endcase
            case ($urandom_range(2))
                0: r.index_word[7:0] = IFACE_FIRST;
                1: r.index_word[7:0] = IFACE_SECOND;
                default: ;
            endcase
        end
        else if (pick < 85)
        begin
            r.request_type[6:5] = KIND_CLASS;
            case ($urandom_range(9))
                0, 1, 2, 3: r.index_word[15:8] = exp_play_id;
                4, 5, 6, 7: r.index_word[15:8] = exp_cap_id;
                default: ;
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3: r.value_word[15:8] = SEL_MUTE;
                4, 5, 6, 7: r.value_word[15:8] = SEL_VOLUME;
                default: ;
            endcase
            if (r.request_type[7])
            begin
                case ($urandom_range(5))
                    0, 4: r.request_code = AC_GET_CUR;
                    1:    r.request_code = AC_GET_MIN;
                    2:    r.request_code = AC_GET_MAX;
                    3:    r.request_code = AC_GET_RES;
                    default: ;
                endcase
            end
            else if ($urandom_range(9) != 0)
                r.request_code = AC_SET_CUR;
            // Zero first byte often enough to clear mute
            if ($urandom_range(3) == 0)
                r.payload_low = 8'h00;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Configuration, alternate setting, status, feature and descriptor
    // requests, including the out-of-range interface and unknown codes.
    task automatic test_standard_requests();
        send_request(make_request(TYPE_STD_IN, RQ_GET_CONFIGURATION, 16'h0000, 16'h0000,
                                  2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_OUT, RQ_SET_CONFIGURATION, 16'hFFFF, 16'hFFFF,
                                  2'd3, 8'hFF, 8'hFF));
        // direction bit ignored on standard requests
        send_request(make_request(TYPE_STD_OUT, RQ_GET_CONFIGURATION, 16'h0000, 16'h0000,
                                  2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_OUT, RQ_SET_INTERFACE, 16'h00FF,
                                  {8'h00, IFACE_FIRST}, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_OUT, RQ_SET_INTERFACE, 16'h0055, 16'hFF03,
                                  2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_IN, RQ_GET_INTERFACE, 16'h0000,
                                  {8'h00, IFACE_FIRST}, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_IN, RQ_GET_INTERFACE, 16'h0000, 16'h00FF,
                                  2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_IN, RQ_GET_STATUS, 16'h0000, 16'h0000,
                                  2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_IN, RQ_SET_FEATURE, 16'h0001, 16'h0000,
                                  2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_IN, RQ_UNKNOWN, 16'h0000, 16'h0000,
                                  2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_IN, RQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00},
                                  16'h0000, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_IN, RQ_GET_DESCRIPTOR, {DESC_STRING, 8'hFF},
                                  16'h0409, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_STD_IN, RQ_GET_DESCRIPTOR, {DESC_OTHER, 8'h00},
                                  16'h0000, 2'd0, 8'h00, 8'h00));
    endtask

    // Mute and volume controls on both units at their reset ids, short
    // payloads, unknown unit or selector, and vendor and reserved types.
    task automatic test_feature_unit_controls();
        send_request(make_request(TYPE_CLASS_IN, AC_GET_CUR, {SEL_MUTE, 8'h00},
                                  {PLAY_UNIT_ID_RST, 8'h00}, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_CLASS_OUT, AC_SET_CUR, {SEL_MUTE, 8'h00},
                                  {CAP_UNIT_ID_RST, 8'h00}, 2'd1, 8'h80, 8'h00));
        send_request(make_request(TYPE_CLASS_IN, AC_GET_CUR, {SEL_MUTE, 8'h00},
                                  {CAP_UNIT_ID_RST, 8'h00}, 2'd0, 8'h00, 8'h00));
        // payload length three acts as two
        send_request(make_request(TYPE_CLASS_OUT, AC_SET_CUR, {SEL_VOLUME, 8'h00},
                                  {PLAY_UNIT_ID_RST, 8'h00}, 2'd3, 8'hFF, 8'h7F));
        send_request(make_request(TYPE_CLASS_IN, AC_GET_CUR, {SEL_VOLUME, 8'h00},
                                  {PLAY_UNIT_ID_RST, 8'h00}, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_CLASS_IN, AC_GET_MIN, {SEL_VOLUME, 8'h00},
                                  {CAP_UNIT_ID_RST, 8'h00}, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_CLASS_IN, AC_GET_RES, {SEL_VOLUME, 8'h00},
                                  {PLAY_UNIT_ID_RST, 8'h00}, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_CLASS_OUT, AC_SET_CUR, {SEL_VOLUME, 8'h00},
                                  {CAP_UNIT_ID_RST, 8'h00}, 2'd1, 8'h12, 8'h34));
        send_request(make_request(TYPE_CLASS_OUT, AC_SET_CUR, {SEL_MUTE, 8'h00},
                                  {PLAY_UNIT_ID_RST, 8'h00}, 2'd0, 8'h01, 8'h00));
        send_request(make_request(TYPE_CLASS_IN, AC_GET_CUR, {SEL_MUTE, 8'h00},
                                  {UNIT_NONE, 8'h00}, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_CLASS_IN, AC_GET_CUR, {SEL_UNKNOWN, 8'h00},
                                  {PLAY_UNIT_ID_RST, 8'h00}, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_CLASS_IN, AC_GET_MIN, {SEL_MUTE, 8'h00},
                                  {PLAY_UNIT_ID_RST, 8'h00}, 2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_VENDOR, RQ_GET_STATUS, 16'h0000, 16'h0000,
                                  2'd0, 8'h00, 8'h00));
        send_request(make_request(TYPE_RESERVED, AC_GET_CUR, {SEL_MUTE, 8'h00},
                                  {PLAY_UNIT_ID_RST, 8'h00}, 2'd2, 8'hFF, 8'hFF));
    endtask

    // One phase of random traffic under new unit ids and idle rates, with a
    // full drain halfway through.
    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [7:0] play_id, input logic [7:0] cap_id);
        wait_until_drained();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_unit_ids(play_id, cap_id);
        repeat (RANDOM_PER_PHASE / 2) send_request(random_request());
        wait_until_drained();
        repeat (RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2) send_request(random_request());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        // Hold every input at a known value through reset
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.request_type = '0;
        req_ch.request_code = '0;
        req_ch.value_word   = '0;
        req_ch.index_word   = '0;
        req_ch.payload_len  = '0;
        req_ch.payload_low  = '0;
        req_ch.payload_high = '0;
        rsp_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        reset_expected_state();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly, sink stalls heavily
        tx_idle_pct = 36;
        rx_idle_pct = 66;
        test_standard_requests();
        test_feature_unit_controls();

        // Low ids at the extremes, then equal ids, then the reverse extremes;
        // idle rates swap, then both sides run flat out.
        test_random_traffic(36, 66, 8'h00, 8'hFF);
        test_random_traffic(66, 36, 8'h07, 8'h07);
        test_random_traffic(0, 0, 8'hFF, 8'h00);

        wait_until_drained();
        if (expected_replies.size() != 0)
        begin
            $error("%0d responses never arrived", expected_replies.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
